// ===== hw/rtl/rrsg_pkg.sv =====
// ----------------------------------------------------------------------------
// rrsg_pkg
// Shared constants, register indexes and types of the rounded rectangle
// span generator.
// ----------------------------------------------------------------------------
package rrsg_pkg;

    localparam int DISPLAY_WIDTH  = 512;
    localparam int DISPLAY_HEIGHT = 512;

    // signed coordinate width for span bounds before clipping
    localparam int COORD_W = 14;
    // clipped column, 0..DISPLAY_WIDTH
    localparam int CLIP_W  = $clog2(DISPLAY_WIDTH + 1);

    // square root unit: 18-bit radicand, 9-bit root, three steps per stage
    localparam int SQ_W        = 18;
    localparam int ROOT_W      = SQ_W / 2;
    localparam int SQRT_STAGES = 3;
    localparam int SQRT_STEPS  = ROOT_W / SQRT_STAGES;

    typedef logic [2:0] t_cfg_idx;

    localparam t_cfg_idx CFG_ORIGIN_X         = 3'd0;
    localparam t_cfg_idx CFG_ORIGIN_Y         = 3'd1;
    localparam t_cfg_idx CFG_RECT_WIDTH       = 3'd2;
    localparam t_cfg_idx CFG_RECT_HEIGHT      = 3'd3;
    localparam t_cfg_idx CFG_CORNER_RADIUS    = 3'd4;
    localparam t_cfg_idx CFG_BORDER_THICKNESS = 3'd5;
    localparam t_cfg_idx CFG_DRAW_MODE        = 3'd6;
    localparam t_cfg_idx CFG_FILL_COLOR       = 3'd7;

    // per-row control data that travels alongside the square root stages
    typedef struct packed {
        logic       empty;
        logic       fillcase;
        logic       inner;
        logic       has_o;
        logic       has_i;
        logic [8:0] rad;
        logic [8:0] in_rad;
        logic [8:0] y;
    } t_side;

    typedef struct packed {
        logic [8:0] x;
        logic [8:0] y;
        logic [9:0] len;
    } t_span;

endpackage

// ===== hw/rtl/rrsg_row_if.sv =====
// ----------------------------------------------------------------------------
// rrsg_row_if
// Row request channel: one row offset per request.
// ----------------------------------------------------------------------------
interface rrsg_row_if;
    logic       valid;
    logic       ready;
    logic [9:0] row_offset;

    modport source(output valid, output row_offset, input ready);
    modport sink(input valid, input row_offset, output ready);
endinterface

// ===== hw/rtl/rrsg_span_if.sv =====
// ----------------------------------------------------------------------------
// rrsg_span_if
// Span channel: one clipped horizontal span per transfer.
// ----------------------------------------------------------------------------
interface rrsg_span_if;
    logic        valid;
    logic        ready;
    logic [8:0]  span_x;
    logic [8:0]  span_y;
    logic [9:0]  span_length;
    logic [15:0] span_color;
    logic        last_span;

    modport source(output valid, output span_x, output span_y, output span_length,
                   output span_color, output last_span, input ready);
    modport sink(input valid, input span_x, input span_y, input span_length,
                 input span_color, input last_span, output ready);
endinterface

// ===== hw/rtl/rounded_rect_span_generator.sv =====
// ----------------------------------------------------------------------------
// rounded_rect_span_generator
// Turns a row offset into up to two clipped spans of a filled or stroked
// rounded rectangle.
// Throughput: one row per cycle while the output is not stalled; a row with two
// spans holds the single output port for both, so the pipeline stalls behind it.
// Reset: registers return to their defaults (thickness 1, others 0) and
// the pipeline and output queue empty at once.
// ----------------------------------------------------------------------------
module rounded_rect_span_generator (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rrsg_row_if.sink              i_row,
    rrsg_span_if.source           o_span,
    input  logic                  i_cfg_we,
    input  rrsg_pkg::t_cfg_idx    i_cfg_idx,
    input  logic [15:0]           i_cfg_data
);
    import rrsg_pkg::*;

    localparam int NSTG = 3 + SQRT_STAGES;

    // configuration
    logic signed [11:0] r_origin_x;
    logic signed [11:0] r_origin_y;
    logic [9:0]         r_rect_width;
    logic [9:0]         r_rect_height;
    logic [8:0]         r_corner_radius;
    logic [8:0]         r_border_thickness;
    logic               r_draw_mode;
    logic [15:0]        r_fill_color;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x         <= '0;
            r_origin_y         <= '0;
            r_rect_width       <= '0;
            r_rect_height      <= '0;
            r_corner_radius    <= '0;
            r_border_thickness <= 9'd1;
            r_draw_mode        <= 1'b0;
            r_fill_color       <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ORIGIN_X:         r_origin_x         <= i_cfg_data[11:0];
                CFG_ORIGIN_Y:         r_origin_y         <= i_cfg_data[11:0];
                CFG_RECT_WIDTH:       r_rect_width       <= i_cfg_data[9:0];
                CFG_RECT_HEIGHT:      r_rect_height      <= i_cfg_data[9:0];
                CFG_CORNER_RADIUS:    r_corner_radius    <= i_cfg_data[8:0];
                CFG_BORDER_THICKNESS: r_border_thickness <= i_cfg_data[8:0];
                CFG_DRAW_MODE:        r_draw_mode        <= i_cfg_data[0];
                CFG_FILL_COLOR:       r_fill_color       <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // pipeline control
    logic        en;
    logic        ld;
    logic        out_acc;
    logic        r_vld [NSTG];
    t_side       r_side [NSTG];
    logic        r_vld_g;
    logic [1:0]  r_q_cnt;
    t_span       r_q [2];

    assign out_acc     = o_span.valid && o_span.ready;
    assign ld          = r_vld_g && (r_q_cnt == 2'd0 || (r_q_cnt == 2'd1 && out_acc));
    assign en          = !r_vld_g || ld;
    assign i_row.ready = en;

    // stage A: row classification and arc distances
    t_side      a_side;
    logic [8:0] a_dy_o;
    logic [8:0] a_dy_i;

    always_comb begin
        logic [9:0]         row;
        logic [9:0]         wmin;
        logic [8:0]         lim;
        logic [8:0]         rad;
        logic [9:0]         two_t;
        logic [9:0]         in_h;
        logic [8:0]         in_rad;
        logic [9:0]         irow;
        logic signed [12:0] y;
        logic               yok;
        row    = i_row.row_offset;
        wmin   = (r_rect_width < r_rect_height) ? r_rect_width : r_rect_height;
        lim    = wmin[9:1];
        rad    = (r_corner_radius > lim) ? lim : r_corner_radius;
        two_t  = {r_border_thickness, 1'b0};
        in_h   = r_rect_height - two_t;
        in_rad = (rad > r_border_thickness) ? rad - r_border_thickness : '0;
        irow   = row - {1'b0, r_border_thickness};
        y      = 13'(r_origin_y) + 13'(row);
        yok    = !y[12] && (y < 13'(DISPLAY_HEIGHT));

        a_side.empty    = (r_rect_width == '0) || (r_rect_height == '0)
                        || (row >= r_rect_height)
                        || (r_draw_mode && r_border_thickness == '0) || !yok;
        a_side.fillcase = !r_draw_mode || (r_rect_width <= two_t)
                        || (r_rect_height <= two_t);
        a_side.inner    = !a_side.fillcase && (row >= {1'b0, r_border_thickness})
                        && (irow < in_h);
        a_side.has_o    = (rad != '0) && ((row < {1'b0, rad})
                        || (row >= r_rect_height - {1'b0, rad}));
        a_side.has_i    = (in_rad != '0) && ((irow < {1'b0, in_rad})
                        || (irow >= in_h - {1'b0, in_rad}));
        a_side.rad      = rad;
        a_side.in_rad   = in_rad;
        a_side.y        = y[8:0];

        a_dy_o = (row < {1'b0, rad}) ? 9'({1'b0, rad} - row)
                                     : 9'(row + 10'd1 + {1'b0, rad} - r_rect_height);
        a_dy_i = (irow < {1'b0, in_rad}) ? 9'({1'b0, in_rad} - irow)
                                         : 9'(irow + 10'd1 + {1'b0, in_rad} - in_h);
    end

    logic [8:0]      r_dy_o;
    logic [8:0]      r_dy_i;
    logic [SQ_W-1:0] r_rr_o;
    logic [SQ_W-1:0] r_dd_o;
    logic [SQ_W-1:0] r_rr_i;
    logic [SQ_W-1:0] r_dd_i;
    logic [SQ_W-1:0] r_sq_o;
    logic [SQ_W-1:0] r_sq_i;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NSTG; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_row.valid;
            for (int k = 1; k < NSTG; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= a_side;
            for (int k = 1; k < NSTG; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_dy_o <= a_dy_o;
            r_dy_i <= a_dy_i;
            // stage B: squares
            r_rr_o <= SQ_W'(r_side[0].rad) * SQ_W'(r_side[0].rad);
            r_dd_o <= SQ_W'(r_dy_o) * SQ_W'(r_dy_o);
            r_rr_i <= SQ_W'(r_side[0].in_rad) * SQ_W'(r_side[0].in_rad);
            r_dd_i <= SQ_W'(r_dy_i) * SQ_W'(r_dy_i);
            // stage C: radicands
            r_sq_o <= r_side[1].has_o ? r_rr_o - r_dd_o : '0;
            r_sq_i <= r_side[1].has_i ? r_rr_i - r_dd_i : '0;
        end
    end

    logic [ROOT_W-1:0] root_o;
    logic [ROOT_W-1:0] root_i;

    rrsg_isqrt u_sqrt_outer (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_sq_o),
        .o_root (root_o)
    );

    rrsg_isqrt u_sqrt_inner (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_sq   (r_sq_i),
        .o_root (root_i)
    );

    // stage G: span bounds before clipping
    t_side                     g_sd;
    logic signed [COORD_W-1:0] g_s0;
    logic signed [COORD_W-1:0] g_e0;
    logic signed [COORD_W-1:0] g_s1;
    logic signed [COORD_W-1:0] g_e1;
    logic                      g_use0;
    logic                      g_use1;

    always_comb begin
        logic [8:0]                ins;
        logic [8:0]                iins;
        logic signed [COORD_W-1:0] ox;
        logic signed [COORD_W-1:0] ot;
        logic signed [COORD_W-1:0] ox0;
        logic signed [COORD_W-1:0] ox1;
        logic signed [COORD_W-1:0] ix0;
        logic signed [COORD_W-1:0] ix1;
        logic [9:0]                in_w;
        g_sd  = r_side[NSTG-1];
        ins   = g_sd.has_o ? g_sd.rad - root_o : '0;
        iins  = g_sd.has_i ? g_sd.in_rad - root_i : '0;
        in_w  = r_rect_width - {r_border_thickness, 1'b0};
        ox    = COORD_W'(r_origin_x);
        ot    = ox + COORD_W'(r_border_thickness);
        ox0   = ox + COORD_W'(ins);
        ox1   = ox + COORD_W'(r_rect_width) - COORD_W'(ins);
        ix0   = ot + COORD_W'(iins);
        ix1   = ot + COORD_W'(in_w) - COORD_W'(iins);

        g_use0 = !g_sd.empty && (ox1 > ox0);
        g_use1 = g_use0 && !g_sd.fillcase && g_sd.inner;
        g_s0   = ox0;
        g_e0   = g_use1 ? ix0 : ox1;
        g_s1   = ix1;
        g_e1   = ox1;
    end

    logic signed [COORD_W-1:0] r_g_s0;
    logic signed [COORD_W-1:0] r_g_e0;
    logic signed [COORD_W-1:0] r_g_s1;
    logic signed [COORD_W-1:0] r_g_e1;
    logic                      r_g_use0;
    logic                      r_g_use1;
    logic [8:0]                r_g_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_g <= 1'b0;
        end else if (en) begin
            r_vld_g <= r_vld[NSTG-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_g_s0   <= g_s0;
            r_g_e0   <= g_e0;
            r_g_s1   <= g_s1;
            r_g_e1   <= g_e1;
            r_g_use0 <= g_use0;
            r_g_use1 <= g_use1;
            r_g_y    <= g_sd.y;
        end
    end

    // clip to the display and pack the pair
    function automatic logic [CLIP_W-1:0] clamp_x(input logic signed [COORD_W-1:0] v);
        logic [CLIP_W-1:0] r;
        if (v[COORD_W-1]) begin
            r = '0;
        end else if (v > COORD_W'(DISPLAY_WIDTH)) begin
            r = CLIP_W'(DISPLAY_WIDTH);
        end else begin
            r = CLIP_W'(v);
        end
        return r;
    endfunction

    logic  ok0;
    logic  ok1;
    t_span sp0;
    t_span sp1;

    always_comb begin
        logic [CLIP_W-1:0] a0;
        logic [CLIP_W-1:0] a1;
        logic [CLIP_W-1:0] b0;
        logic [CLIP_W-1:0] b1;
        a0 = clamp_x(r_g_s0);
        a1 = clamp_x(r_g_e0);
        b0 = clamp_x(r_g_s1);
        b1 = clamp_x(r_g_e1);
        ok0 = r_g_use0 && (a1 > a0);
        ok1 = r_g_use1 && (b1 > b0);
        sp0.x   = 9'(a0);
        sp0.y   = r_g_y;
        sp0.len = 10'(a1 - a0);
        sp1.x   = 9'(b0);
        sp1.y   = r_g_y;
        sp1.len = 10'(b1 - b0);
    end

    // output queue: up to the two spans of one row
    logic [1:0] n_q_cnt;
    t_span      n_q [2];

    always_comb begin
        n_q_cnt = r_q_cnt;
        n_q[0]  = r_q[0];
        n_q[1]  = r_q[1];
        if (ld) begin
            n_q_cnt = {1'b0, ok0} + {1'b0, ok1};
            n_q[0]  = ok0 ? sp0 : sp1;
            n_q[1]  = sp1;
        end else if (out_acc) begin
            // advance to the second span, or drain
            n_q_cnt = r_q_cnt - 2'd1;
            n_q[0]  = r_q[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_cnt <= '0;
        end else begin
            r_q_cnt <= n_q_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q[0] <= n_q[0];
        r_q[1] <= n_q[1];
    end

    assign o_span.valid       = (r_q_cnt != 2'd0);
    assign o_span.span_x      = r_q[0].x;
    assign o_span.span_y      = r_q[0].y;
    assign o_span.span_length = r_q[0].len;
    assign o_span.span_color  = r_fill_color;
    assign o_span.last_span   = (r_q_cnt == 2'd1);

endmodule

// ===== hw/rtl/rrsg_isqrt.sv =====
// ----------------------------------------------------------------------------
// rrsg_isqrt
// Pipelined floor square root, a few digit steps per register stage.
// ----------------------------------------------------------------------------
module rrsg_isqrt (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [rrsg_pkg::SQ_W-1:0]   i_sq,
    output logic [rrsg_pkg::ROOT_W-1:0] o_root
);
    import rrsg_pkg::*;

    logic [SQ_W-1:0] r_rem [SQRT_STAGES];
    logic [SQ_W-1:0] r_res [SQRT_STAGES];
    logic [SQ_W-1:0] n_rem [SQRT_STAGES];
    logic [SQ_W-1:0] n_res [SQRT_STAGES];
    logic [SQ_W-1:0] w_rem_in [SQRT_STAGES];
    logic [SQ_W-1:0] w_res_in [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++) begin : g_stg
        if (s == 0) begin : g_first
            assign w_rem_in[s] = i_sq;
            assign w_res_in[s] = '0;
        end else begin : g_next
            assign w_rem_in[s] = r_rem[s-1];
            assign w_res_in[s] = r_res[s-1];
        end

        always_comb begin
            logic [SQ_W-1:0] rem;
            logic [SQ_W-1:0] res;
            logic [SQ_W-1:0] bitv;
            logic [SQ_W:0]   trial;
            rem = w_rem_in[s];
            res = w_res_in[s];
            for (int j = 0; j < SQRT_STEPS; j++) begin
                bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * (s * SQRT_STEPS + j));
                trial = {1'b0, res} + {1'b0, bitv};
                if ({1'b0, rem} >= trial) begin
                    rem = rem - trial[SQ_W-1:0];
                    res = (res >> 1) + bitv;
                end else begin
                    res = res >> 1;
                end
            end
            n_rem[s] = rem;
            n_res[s] = res;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s] <= n_rem[s];
                r_res[s] <= n_res[s];
            end
        end
    end

    assign o_root = r_res[SQRT_STAGES-1][ROOT_W-1:0];

endmodule

// ===== tb/sv/rrsg_span_checker.sv =====
// ----------------------------------------------------------------------------
// rrsg_span_checker
// Watches the row, span and register ports of the span generator. Keeps its
// own copy of the registers, works out the spans each accepted row request
// must give and compares every span that leaves the block against them.
// ----------------------------------------------------------------------------
module rrsg_span_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    rrsg_row_if                   i_row,
    rrsg_span_if                  i_span,
    input  logic                  i_cfg_we,
    input  rrsg_pkg::t_cfg_idx    i_cfg_idx,
    input  logic [15:0]           i_cfg_data,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import rrsg_pkg::*;

    typedef struct packed {
        logic [8:0]  x;
        logic [8:0]  y;
        logic [9:0]  len;
        logic [15:0] color;
        logic        last;
    } t_span_rec;

    // register copy
    int          org_x;
    int          org_y;
    int          width;
    int          height;
    int          radius;
    int          thick;
    logic        stroke;
    logic [15:0] color;

    t_span_rec   span_q[$];
    int          fails;

    function automatic int unsigned floor_sqrt(input int unsigned v);
        int unsigned rem;
        int unsigned root;
        int unsigned b;
        rem  = v;
        root = 0;
        b    = 32'd1 << 30;
        while (b > rem) begin
            b = b >> 2;
        end
        while (b != 0) begin
            if (rem >= root + b) begin
                rem  = rem - (root + b);
                root = (root >> 1) + b;
            end else begin
                root = root >> 1;
            end
            b = b >> 2;
        end
        return root;
    endfunction

    // same inset on both sides of a row that falls inside a corner arc
    function automatic int arc_edge_inset(input int row, input int h, input int rad);
        int dy;
        int sq;
        if (rad <= 0 || h <= 0) begin
            return 0;
        end
        if (row < rad) begin
            dy = rad - row;
        end else if (row >= h - rad) begin
            dy = row - (h - 1 - rad);
        end else begin
            return 0;
        end
        sq = rad * rad - dy * dy;
        return rad - ((sq > 0) ? int'(floor_sqrt(sq)) : 0);
    endfunction

    // clamp to the display columns; drop empty or off-display spans
    function automatic void clip_span(input int x, input int y, input int len,
                                      ref t_span_rec spans[$]);
        int        x0;
        int        x1;
        t_span_rec s;
        if (len <= 0 || y < 0 || y >= DISPLAY_HEIGHT) begin
            return;
        end
        x0 = (x < 0) ? 0 : ((x > DISPLAY_WIDTH) ? DISPLAY_WIDTH : x);
        x1 = x + len;
        x1 = (x1 < 0) ? 0 : ((x1 > DISPLAY_WIDTH) ? DISPLAY_WIDTH : x1);
        if (x1 <= x0) begin
            return;
        end
        s.x     = 9'(x0);
        s.y     = 9'(y);
        s.len   = 10'(x1 - x0);
        s.color = color;
        s.last  = 1'b0;
        spans.push_back(s);
    endfunction

    function automatic void predict_row(input int row);
        int        lim;
        int        rad;
        int        y;
        int        ins;
        int        in_w;
        int        in_h;
        int        in_rad;
        int        ox0;
        int        ox1;
        int        irow;
        int        iins;
        int        ix0;
        int        ix1;
        t_span_rec spans[$];
        if (width <= 0 || height <= 0 || row >= height) begin
            return;
        end
        if (stroke && thick <= 0) begin
            return;
        end
        lim = (width < height) ? width / 2 : height / 2;
        rad = (radius > lim) ? lim : radius;
        y   = org_y + row;
        ins = arc_edge_inset(row, height, rad);
        if (!stroke || width - 2 * thick <= 0 || height - 2 * thick <= 0) begin
            clip_span(org_x + ins, y, width - 2 * ins, spans);
        end else begin
            in_w   = width - 2 * thick;
            in_h   = height - 2 * thick;
            in_rad = (rad > thick) ? rad - thick : 0;
            ox0    = org_x + ins;
            ox1    = org_x + width - ins;
            irow   = row - thick;
            if (ox1 <= ox0) begin
                return;
            end
            if (irow < 0 || irow >= in_h) begin
                clip_span(ox0, y, ox1 - ox0, spans);
            end else begin
                // inside the inner window: left and right bands only
                iins = arc_edge_inset(irow, in_h, in_rad);
                ix0  = org_x + thick + iins;
                ix1  = org_x + thick + in_w - iins;
                clip_span(ox0, y, ix0 - ox0, spans);
                clip_span(ix1, y, ox1 - ix1, spans);
            end
        end
        if (spans.size() > 0) begin
            spans[spans.size() - 1].last = 1'b1;
        end
        foreach (spans[k]) begin
            span_q.push_back(spans[k]);
        end
    endfunction

    always @(posedge i_clk) begin
        t_span_rec got;
        t_span_rec want;
        if (!i_rst_n) begin
            org_x  = 0;
            org_y  = 0;
            width  = 0;
            height = 0;
            radius = 0;
            thick  = 1;
            stroke = 1'b0;
            color  = 16'h0000;
            span_q.delete();
        end else begin
            if (i_span.valid && i_span.ready) begin
                got.x     = i_span.span_x;
                got.y     = i_span.span_y;
                got.len   = i_span.span_length;
                got.color = i_span.span_color;
                got.last  = i_span.last_span;
                if (span_q.size() == 0) begin
                    if (fails < 10) begin
                        $display("unexpected span: x=%0d y=%0d len=%0d color=%h last=%0d",
                                 got.x, got.y, got.len, got.color, got.last);
                    end
                    fails++;
                end else begin
                    want = span_q.pop_front();
                    if (got.x !== want.x || got.y !== want.y || got.len !== want.len ||
                        got.color !== want.color || got.last !== want.last) begin
                        if (fails < 10) begin
                            $display("span mismatch");
                            $display("  expected x=%0d y=%0d len=%0d color=%h last=%0d",
                                     want.x, want.y, want.len, want.color, want.last);
                            $display("  actual   x=%0d y=%0d len=%0d color=%h last=%0d",
                                     got.x, got.y, got.len, got.color, got.last);
                        end
                        fails++;
                    end
                end
            end
            if (i_row.valid && i_row.ready) begin
                predict_row(int'(i_row.row_offset));
            end
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_ORIGIN_X:         org_x  = int'($signed(i_cfg_data[11:0]));
                    CFG_ORIGIN_Y:         org_y  = int'($signed(i_cfg_data[11:0]));
                    CFG_RECT_WIDTH:       width  = int'(i_cfg_data[9:0]);
                    CFG_RECT_HEIGHT:      height = int'(i_cfg_data[9:0]);
                    CFG_CORNER_RADIUS:    radius = int'(i_cfg_data[8:0]);
                    CFG_BORDER_THICKNESS: thick  = int'(i_cfg_data[8:0]);
                    CFG_DRAW_MODE:        stroke = i_cfg_data[0];
                    CFG_FILL_COLOR:       color  = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= span_q.size();
        o_fail_count <= fails;
    end

endmodule

// ===== tb/sv/tb_rounded_rect_span_generator.sv =====
// ----------------------------------------------------------------------------
// tb_rounded_rect_span_generator
// Drives row requests and register settings into the span generator with
// random gaps and output stalls. A directed pass covers corners, stroke
// bands, thick strokes, clipping and off-display rows; random settings with
// row requests follow. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_rounded_rect_span_generator;
    timeunit 1ns;
    timeprecision 1ps;
    import rrsg_pkg::*;

    localparam int RANDOM_ROWS = 1750;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE_CYCLES = 16;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    t_cfg_idx    cfg_idx;
    logic [15:0] cfg_data;
    int          fail_count;
    int          pending;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          cur_height;
    int          quiet;

    rrsg_row_if  row_ch();
    rrsg_span_if span_ch();

    rounded_rect_span_generator i_dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_row      (row_ch),
        .o_span     (span_ch),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    rrsg_span_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_row        (row_ch),
        .i_span       (span_ch),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            span_ch.ready <= 1'b0;
        end else begin
            span_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // end the run when neither channel moves for too long
    always @(posedge clk) begin
        if ((row_ch.valid && row_ch.ready) || (span_ch.valid && span_ch.ready)) begin
            quiet <= 0;
        end else if (quiet >= STALL_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    task automatic send_row(input logic [9:0] row);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            row_ch.valid <= 1'b0;
            @(posedge clk);
        end
        row_ch.valid      <= 1'b1;
        row_ch.row_offset <= row;
        @(posedge clk);
        while (!row_ch.ready) begin
            @(posedge clk);
        end
    endtask

    // hold until every span is out, then let rows without spans leave the pipe
    task automatic wait_idle();
        row_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input int value, input int bits);
        logic [15:0] mask;
        logic [15:0] word;
        mask = 16'((32'd1 << bits) - 1);
        word = 16'(value) & mask;
        // unused upper bits must be ignored
        if ($urandom_range(0, 3) == 0) begin
            word = word | (16'($urandom) & ~mask);
        end
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= word;
        @(posedge clk);
    endtask

    task automatic apply_settings(input int ox, input int oy, input int w, input int h,
                                  input int r, input int t, input int m, input int c);
        wait_idle();
        write_reg(CFG_ORIGIN_X, ox, 12);
        write_reg(CFG_ORIGIN_Y, oy, 12);
        write_reg(CFG_RECT_WIDTH, w, 10);
        write_reg(CFG_RECT_HEIGHT, h, 10);
        write_reg(CFG_CORNER_RADIUS, r, 9);
        write_reg(CFG_BORDER_THICKNESS, t, 9);
        write_reg(CFG_DRAW_MODE, m, 1);
        write_reg(CFG_FILL_COLOR, c, 16);
        cfg_we     <= 1'b0;
        cur_height = h & 10'h3FF;
    endtask

    function automatic int pick_origin();
        int v;
        if ($urandom_range(0, 9) == 0) begin
            v = int'($signed(12'($urandom)));
        end else begin
            v = int'($urandom_range(0, 760)) - 200;
        end
        return v;
    endfunction

    function automatic int pick_size(input int typical);
        int v;
        case ($urandom_range(0, 9))
            0:       v = $urandom_range(0, 1023);
            1:       v = $urandom_range(0, 3);
            default: v = $urandom_range(1, typical);
        endcase
        return v;
    endfunction

    task automatic random_settings();
        int ox;
        int oy;
        int w;
        int h;
        int r;
        int t;
        int sel;
        ox  = pick_origin();
        oy  = pick_origin();
        w   = pick_size(64);
        h   = pick_size(48);
        r   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 511) : $urandom_range(0, 30);
        sel = $urandom_range(0, 9);
        if (sel < 7) begin
            t = $urandom_range(0, 8);
        end else if (sel < 9) begin
            t = $urandom_range(0, 30);
        end else begin
            t = $urandom_range(0, 511);
        end
        apply_settings(ox, oy, w, h, r, t, $urandom_range(0, 1), $urandom_range(0, 65535));
    endtask

    // mostly rows inside the rectangle, some anywhere
    function automatic logic [9:0] pick_row();
        if (cur_height > 0 && $urandom_range(0, 99) < 85) begin
            return 10'($urandom_range(0, cur_height - 1));
        end
        return 10'($urandom_range(0, 1023));
    endfunction

    initial begin
        int rows_sent;
        int n;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_idx           = CFG_ORIGIN_X;
        cfg_data          = 16'h0000;
        row_ch.valid      = 1'b0;
        row_ch.row_offset = 10'd0;
        cur_height        = 0;
        send_idle_pct     = 37;
        recv_idle_pct     = 55;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: empty rectangle
        send_row(10'd0);

        // filled, corners and the row past the height
        apply_settings(0, 0, 20, 10, 4, 1, 0, 16'hFFFF);
        send_row(10'd0);
        send_row(10'd1);
        send_row(10'd5);
        send_row(10'd9);
        send_row(10'd10);

        // stroke with an inner window
        apply_settings(0, 0, 20, 10, 4, 2, 1, 16'h0000);
        send_row(10'd0);
        send_row(10'd2);
        send_row(10'd5);
        send_row(10'd8);

        // stroke thicker than half the height falls back to fill
        apply_settings(0, 0, 20, 10, 4, 6, 1, 16'hA5A5);
        send_row(10'd3);

        // zero thickness stroke
        apply_settings(0, 0, 20, 10, 4, 0, 1, 16'h5A5A);
        send_row(10'd0);

        // largest rectangle, radius at its limit, right clip and bottom of display
        apply_settings(500, -511, 1023, 1023, 511, 1, 0, 16'h1234);
        send_row(10'd511);
        send_row(10'd1022);
        send_row(10'd1023);

        // far off the display on both extremes
        apply_settings(-2048, -2048, 1023, 1023, 0, 511, 1, 16'hFFFF);
        send_row(10'd0);
        apply_settings(2047, 2047, 100, 100, 10, 511, 0, 16'h0001);
        send_row(10'd5);

        // left clip on a stroked outline
        apply_settings(-100, 100, 300, 30, 10, 3, 1, 16'h07E0);
        send_row(10'd0);
        send_row(10'd4);
        send_row(10'd15);
        send_row(10'd29);

        rows_sent = 0;
        while (rows_sent < RANDOM_ROWS) begin
            if (rows_sent >= 2 * RANDOM_ROWS / 3) begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end else if (rows_sent >= RANDOM_ROWS / 3) begin
                send_idle_pct = 55;
                recv_idle_pct = 37;
            end
            random_settings();
            n = $urandom_range(15, 40);
            repeat (n) begin
                send_row(pick_row());
                rows_sent++;
            end
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
